>>> hw/rtl/fcfs_pkg.sv
package fcfs_pkg;

    localparam int IN_W   = 16;
    localparam int ID_W   = 5;
    localparam int RES_W  = 21;
    localparam int AVG_W  = 29;
    localparam int FRAC_W = 8;

    typedef struct packed {
        logic [IN_W-1:0] arrival_time;
        logic [IN_W-1:0] burst_time;
        logic            last_item;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]  process_id;
        logic [RES_W-1:0] turnaround;
        logic [RES_W-1:0] wait_time;
        logic [AVG_W-1:0] avg_turnaround_q8;
        logic [AVG_W-1:0] avg_wait_q8;
        logic             overflow;
        logic             last_result;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_RUN_CHK,
        ST_RP_ADDR,
        ST_RP_START,
        ST_RP_CALC,
        ST_RP_TA,
        ST_RP_EMIT,
        ST_DIV_TA,
        ST_DIV_TA_WAIT,
        ST_DIV_WT,
        ST_DIV_WT_WAIT,
        ST_FINAL
    } state_t;

endpackage

>>> hw/rtl/fcfs_table.sv
module fcfs_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 37
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/fcfs_div.sv
module fcfs_div #(
    parameter int DW = 35,
    parameter int NW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [NW:0]   rem_shift;
    logic [NW+1:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DW-1]};
        diff      = {1'b0, rem_shift} - {2'b00, divisor};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            cnt_next = CW'(DW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[NW+1])
            begin
                rem_next = diff[NW-1:0];
                dvd_next = {dvd_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[NW-1:0];
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule

>>> hw/rtl/fcfs_schedule_metrics_core.sv
// Insert: each stored entry with a later arrival is read (INS_RD) and shifted up (INS_CMP);
// the walk stops on an equal or earlier arrival or at slot 0, then INS_PUT writes the item.
// An item into an empty table goes straight to INS_PUT. Last item adds a check (RUN_CHK),
// RP_ADDR to RP_EMIT per stored entry, two serial divides and a state that loads the final result.
// Items are accepted only while idle; a dropped unmarked item leaves the core idle. Results
// are one-cycle strobes the receiver cannot stall. Reset clears count and flags.
module fcfs_schedule_metrics_core #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fcfs_pkg::item_t     item,
    output logic                busy,
    output logic                result_valid,
    output fcfs_pkg::result_t   result
);
    import fcfs_pkg::*;

    // Stored time width: inputs are only IN_W bits wide, then masked to TIME_BITS.
    localparam int SW    = (TIME_BITS < IN_W) ? TIME_BITS : IN_W;
    localparam int AW    = $clog2(MAX_PROCS);
    localparam int CNTW  = $clog2(MAX_PROCS + 1);
    localparam int IDW   = CNTW;
    localparam int EW    = IDW + 2 * SW;
    // The schedule clock stays below (count + 1) * 2^SW.
    localparam int CW    = SW + CNTW + 1;
    localparam int SUMW  = CW + CNTW;
    localparam int DW    = SUMW + FRAC_W;

    state_t state_reg, state_next;

    logic [CNTW-1:0] count_reg, count_next;
    logic            dropped_reg, dropped_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [CNTW-1:0] j_reg, j_next;
    logic [SW-1:0]   new_arr_reg, new_arr_next;
    logic [SW-1:0]   new_bur_reg, new_bur_next;
    logic            last_reg, last_next;

    logic [CW-1:0]   clock_reg, clock_next;
    logic [CW-1:0]   start_reg, start_next;
    logic [CW-1:0]   wt_reg, wt_next;
    logic [CW-1:0]   ta_reg, ta_next;
    logic [SUMW-1:0] sum_ta_reg, sum_ta_next;
    logic [SUMW-1:0] sum_wt_reg, sum_wt_next;
    logic [AVG_W-1:0] avg_ta_reg, avg_ta_next;

    logic            res_valid_reg, res_valid_next;
    result_t         res_reg, res_next;

    // Table port
    logic            tbl_we;
    logic [AW-1:0]   tbl_waddr;
    logic [EW-1:0]   tbl_wdata;
    logic            tbl_re;
    logic [AW-1:0]   tbl_raddr;
    logic [EW-1:0]   tbl_rdata;

    logic [SW-1:0]   rd_arr;
    logic [SW-1:0]   rd_bur;
    logic [IDW-1:0]  rd_id;
    logic [IDW-1:0]  new_id;

    // Divider
    logic            div_start;
    logic [DW-1:0]   div_dividend;
    logic            div_done;
    logic [DW-1:0]   div_quot;

    // Zero-extended views, cut down to the output field widths.
    logic [IDW+ID_W-1:0]  id_ext;
    logic [CW+RES_W-1:0]  ta_ext;
    logic [CW+RES_W-1:0]  wt_ext;
    logic [DW+AVG_W-1:0]  quot_ext;

    assign rd_arr = tbl_rdata[SW-1:0];
    assign rd_bur = tbl_rdata[2*SW-1:SW];
    assign rd_id  = tbl_rdata[EW-1:2*SW];
    assign new_id = count_reg + IDW'(1);

    assign id_ext   = (IDW + ID_W)'(rd_id);
    assign ta_ext   = (CW + RES_W)'(ta_reg);
    assign wt_ext   = (CW + RES_W)'(wt_reg);
    assign quot_ext = (DW + AVG_W)'(div_quot);

    fcfs_table #(
        .DEPTH (MAX_PROCS),
        .WIDTH (EW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    fcfs_div #(
        .DW (DW),
        .NW (CNTW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        j_reg       <= j_next;
        new_arr_reg <= new_arr_next;
        new_bur_reg <= new_bur_next;
        last_reg    <= last_next;
        clock_reg   <= clock_next;
        start_reg   <= start_next;
        wt_reg      <= wt_next;
        ta_reg      <= ta_next;
        sum_ta_reg  <= sum_ta_next;
        sum_wt_reg  <= sum_wt_next;
        avg_ta_reg  <= avg_ta_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        new_arr_next   = new_arr_reg;
        new_bur_next   = new_bur_reg;
        last_next      = last_reg;
        clock_next     = clock_reg;
        start_next     = start_reg;
        wt_next        = wt_reg;
        ta_next        = ta_reg;
        sum_ta_next    = sum_ta_reg;
        sum_wt_next    = sum_wt_reg;
        avg_ta_next    = avg_ta_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        tbl_we       = 1'b0;
        tbl_waddr    = k_reg;
        tbl_wdata    = {new_id, new_bur_reg, new_arr_reg};
        tbl_re       = 1'b0;
        tbl_raddr    = j_reg[AW-1:0];
        div_start    = 1'b0;
        div_dividend = {sum_ta_reg, {FRAC_W{1'b0}}};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    new_arr_next = item.arrival_time[SW-1:0];
                    new_bur_next = item.burst_time[SW-1:0];
                    last_next    = item.last_item;
                    k_next       = count_reg[AW-1:0];
                    if (count_reg == CNTW'(MAX_PROCS))
                    begin
                        // Table full: drop the beat, keep its last mark.
                        dropped_next = 1'b1;
                        state_next   = item.last_item ? ST_RUN_CHK : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        state_next = ST_INS_RD;
                    end
                end
            end

            ST_INS_RD:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = k_reg - AW'(1);
                state_next = ST_INS_CMP;
            end

            ST_INS_CMP:
            begin
                // Shift a later arrival up one slot; stop at the first equal or earlier.
                if (rd_arr > new_arr_reg)
                begin
                    tbl_we     = 1'b1;
                    tbl_wdata  = tbl_rdata;
                    k_next     = k_reg - AW'(1);
                    state_next = (k_reg == AW'(1)) ? ST_INS_PUT : ST_INS_RD;
                end
                else
                begin
                    state_next = ST_INS_PUT;
                end
            end

            ST_INS_PUT:
            begin
                tbl_we     = 1'b1;
                count_next = count_reg + CNTW'(1);
                state_next = last_reg ? ST_RUN_CHK : ST_IDLE;
            end

            ST_RUN_CHK:
            begin
                if (count_reg == '0)
                begin
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    clock_next  = '0;
                    sum_ta_next = '0;
                    sum_wt_next = '0;
                    j_next      = '0;
                    state_next  = ST_RP_ADDR;
                end
            end

            ST_RP_ADDR:
            begin
                tbl_re     = 1'b1;
                state_next = ST_RP_START;
            end

            ST_RP_START:
            begin
                start_next = (clock_reg > CW'(rd_arr)) ? clock_reg : CW'(rd_arr);
                state_next = ST_RP_CALC;
            end

            ST_RP_CALC:
            begin
                wt_next    = start_reg - CW'(rd_arr);
                clock_next = start_reg + CW'(rd_bur);
                state_next = ST_RP_TA;
            end

            ST_RP_TA:
            begin
                ta_next    = wt_reg + CW'(rd_bur);
                state_next = ST_RP_EMIT;
            end

            ST_RP_EMIT:
            begin
                sum_ta_next                = sum_ta_reg + SUMW'(ta_reg);
                sum_wt_next                = sum_wt_reg + SUMW'(wt_reg);
                res_next.process_id        = id_ext[ID_W-1:0];
                res_next.turnaround        = ta_ext[RES_W-1:0];
                res_next.wait_time         = wt_ext[RES_W-1:0];
                res_next.avg_turnaround_q8 = '0;
                res_next.avg_wait_q8       = '0;
                res_next.overflow          = dropped_reg;
                res_next.last_result       = 1'b0;
                if (j_reg + CNTW'(1) == count_reg)
                begin
                    // Hold the final beat until both averages are known.
                    state_next = ST_DIV_TA;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    j_next         = j_reg + CNTW'(1);
                    state_next     = ST_RP_ADDR;
                end
            end

            ST_DIV_TA:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_TA_WAIT;
            end

            ST_DIV_TA_WAIT:
            begin
                if (div_done)
                begin
                    avg_ta_next = quot_ext[AVG_W-1:0];
                    state_next  = ST_DIV_WT;
                end
            end

            ST_DIV_WT:
            begin
                div_start    = 1'b1;
                div_dividend = {sum_wt_reg, {FRAC_W{1'b0}}};
                state_next   = ST_DIV_WT_WAIT;
            end

            ST_DIV_WT_WAIT:
            begin
                if (div_done)
                begin
                    res_next.avg_wait_q8 = quot_ext[AVG_W-1:0];
                    state_next           = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                // Emit the final beat and empty the table.
                res_next.avg_turnaround_q8 = avg_ta_reg;
                res_next.last_result       = 1'b1;
                res_valid_next             = 1'b1;
                count_next                 = '0;
                dropped_next               = 1'b0;
                state_next                 = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
endmodule
